// File: hw/rtl/bole_pkg.sv
// Shared types and codes for the bounded ordered list engine.
// No dependencies; every other file in hw/rtl imports this package.
package bole_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int VAL_W        = 32;
    localparam int OPC_W        = 3;
    localparam int STAT_W       = 2;
    localparam int ECNT_W       = 6;

    localparam logic [OPC_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OPC_W-1:0] OP_INS_TAIL  = 3'd1;
    localparam logic [OPC_W-1:0] OP_REM_FRONT = 3'd2;
    localparam logic [OPC_W-1:0] OP_REM_MATCH = 3'd3;
    localparam logic [OPC_W-1:0] OP_CLEAR     = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [OPC_W-1:0]        opcode;
        logic signed [VAL_W-1:0] operand_value;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] removed_value;
        logic [ECNT_W-1:0]       element_count;
    } out_item_t;

    // Write enables into the slot store.
    typedef struct packed {
        logic val_we;
        logic lnk_we;
    } store_we_t;

    // Requests to the slot allocator.
    typedef struct packed {
        logic take;
        logic give;
        logic clear;
    } alloc_ctl_t;

endpackage

// File: hw/rtl/bole_store.sv
// Slot store: element values and next-slot links, one read address shared by both.
// Depends on bole_pkg.
module bole_store #(
    parameter int  CAPACITY = bole_pkg::DEF_CAPACITY,
    localparam int SW       = $clog2(CAPACITY)
) (
    input  logic                              aclk,
    input  bole_pkg::store_we_t               we,
    input  logic [SW-1:0]                     val_waddr,
    input  logic signed [bole_pkg::VAL_W-1:0] val_wdata,
    input  logic [SW-1:0]                     lnk_waddr,
    input  logic [SW-1:0]                     lnk_wdata,
    input  logic [SW-1:0]                     rd_addr,
    output logic signed [bole_pkg::VAL_W-1:0] val_rdata,
    output logic [SW-1:0]                     lnk_rdata
);
    import bole_pkg::*;

    logic signed [VAL_W-1:0] val_mem [CAPACITY];
    logic [SW-1:0]           lnk_mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (we.val_we) begin
            val_mem[val_waddr] <= val_wdata;
        end
        val_rdata <= val_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (we.lnk_we) begin
            lnk_mem[lnk_waddr] <= lnk_wdata;
        end
        lnk_rdata <= lnk_mem[rd_addr];
    end

endmodule

// File: hw/rtl/bole_alloc.sv
// Slot allocator: a stack of returned slots plus a counter of never-used slots.
// Depends on bole_pkg.
module bole_alloc #(
    parameter int  CAPACITY = bole_pkg::DEF_CAPACITY,
    localparam int SW       = $clog2(CAPACITY),
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bole_pkg::alloc_ctl_t ctl,
    input  logic [SW-1:0]        give_slot,
    output logic [SW-1:0]        slot
);
    import bole_pkg::*;

    logic [SW-1:0] stk_mem [CAPACITY];
    logic [SW-1:0] stk_rd_reg;
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] fresh_reg, fresh_next;
    logic          from_stk_reg, from_stk_next;
    logic [SW-1:0] fresh_slot_reg;
    logic [CW-1:0] sp_top;

    assign sp_top = sp_reg - CW'(1);

    always_ff @(posedge aclk) begin
        if (ctl.give) begin
            stk_mem[sp_reg[SW-1:0]] <= give_slot;
        end
        stk_rd_reg <= stk_mem[sp_top[SW-1:0]];
    end

    always_comb begin
        sp_next       = sp_reg;
        fresh_next    = fresh_reg;
        from_stk_next = from_stk_reg;
        if (ctl.clear) begin
            sp_next    = '0;
            fresh_next = '0;
        end else if (ctl.take) begin
            // prefer a returned slot; else hand out the next untouched one
            from_stk_next = (sp_reg != '0);
            if (sp_reg != '0) begin
                sp_next = sp_top;
            end else begin
                fresh_next = fresh_reg + CW'(1);
            end
        end else if (ctl.give) begin
            sp_next = sp_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg       <= '0;
            fresh_reg    <= '0;
            from_stk_reg <= 1'b0;
        end else begin
            sp_reg       <= sp_next;
            fresh_reg    <= fresh_next;
            from_stk_reg <= from_stk_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            fresh_slot_reg <= fresh_reg[SW-1:0];
        end
    end

    assign slot = from_stk_reg ? stk_rd_reg : fresh_slot_reg;

    a_sp_le_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= fresh_reg)
        else $error("free stack deeper than slots ever handed out");
    a_fresh_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= CW'(CAPACITY))
        else $error("fresh slot counter past capacity");
    a_take_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.take && !ctl.clear |-> (sp_reg != '0) || (fresh_reg != CW'(CAPACITY)))
        else $error("slot taken with no free slot");

endmodule

// File: hw/rtl/bounded_ordered_list_engine_unit.sv
// Top level of the bounded ordered list engine: command sequencer and result register.
// Depends on bole_pkg, bole_store and bole_alloc.
//
//   channel | direction | ports                    | item
//   s_      | in        | s_valid s_ready s_data   | in_item_t  (opcode, operand_value)
//   m_      | out       | m_valid m_ready m_data   | out_item_t (status, removed_value, count)
//
// Insert front runs S_INS, S_FIN; insert tail S_INS, S_TAIL (skipped when empty),
// S_FIN; remove front S_POP, S_FIN; clear and commands refused at once go straight
// to S_FIN. Remove by value walks the links one slot per cycle in S_WALK to a match
// or the last element. s_ready is high whenever the sequencer is idle, also while
// an earlier result waits in the output register; a held result only stalls the
// sequencer at its last step. Reset empties the list.
module bounded_ordered_list_engine_unit #(
    parameter int CAPACITY = bole_pkg::DEF_CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bole_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bole_pkg::out_item_t m_data
);
    import bole_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INS  = 6'b000010,
        S_TAIL = 6'b000100,
        S_POP  = 6'b001000,
        S_WALK = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [OPC_W-1:0]        op_reg, op_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [SW-1:0]           head_reg, head_next;
    logic [SW-1:0]           tail_reg, tail_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [SW-1:0]           cur_reg, cur_next;
    logic [SW-1:0]           prev_reg, prev_next;
    logic [STAT_W-1:0]       stat_reg, stat_next;
    logic signed [VAL_W-1:0] rem_reg, rem_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    store_we_t               st_we;
    logic [SW-1:0]           val_waddr, lnk_waddr, lnk_wdata, rd_addr;
    logic signed [VAL_W-1:0] val_rdata;
    logic [SW-1:0]           lnk_rdata;
    alloc_ctl_t              al_ctl;
    logic [SW-1:0]           al_give, al_slot;

    logic accept, out_free, full, empty, hit, last;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign full     = (cnt_reg == CW'(CAPACITY));
    assign empty    = (cnt_reg == '0);
    assign hit      = (val_rdata == val_reg);
    assign last     = ((idx_reg + CW'(1)) == cnt_reg);
    // follow the link just read while walking; otherwise point at the head
    assign rd_addr  = (state_reg == S_WALK) ? lnk_rdata : head_reg;

    bole_store #(.CAPACITY(CAPACITY)) u_store (
        .aclk      (aclk),
        .we        (st_we),
        .val_waddr (val_waddr),
        .val_wdata (val_reg),
        .lnk_waddr (lnk_waddr),
        .lnk_wdata (lnk_wdata),
        .rd_addr   (rd_addr),
        .val_rdata (val_rdata),
        .lnk_rdata (lnk_rdata)
    );

    bole_alloc #(.CAPACITY(CAPACITY)) u_alloc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (al_ctl),
        .give_slot (al_give),
        .slot      (al_slot)
    );

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        stat_next    = stat_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        st_we        = '0;
        val_waddr    = al_slot;
        lnk_waddr    = al_slot;
        lnk_wdata    = al_slot;
        al_ctl       = '0;
        al_give      = cur_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next   = s_data.opcode;
                    val_next  = s_data.operand_value;
                    stat_next = ST_DONE;
                    rem_next  = '0;
                    idx_next  = '0;
                    cur_next  = head_reg;
                    prev_next = head_reg;
                    state_next = S_FIN;
                    case (s_data.opcode)
                        OP_INS_FRONT, OP_INS_TAIL: begin
                            if (full) begin
                                stat_next = ST_FULL;
                            end else begin
                                al_ctl.take = 1'b1;
                                state_next  = S_INS;
                            end
                        end
                        OP_REM_FRONT: begin
                            if (empty) begin
                                stat_next = ST_MISS;
                            end else begin
                                state_next = S_POP;
                            end
                        end
                        OP_REM_MATCH: begin
                            if (empty) begin
                                stat_next = ST_MISS;
                            end else begin
                                state_next = S_WALK;
                            end
                        end
                        OP_CLEAR: begin
                            al_ctl.clear = 1'b1;
                            cnt_next     = '0;
                            head_next    = '0;
                            tail_next    = '0;
                        end
                        default: begin
                            // unused opcodes: report the count, change nothing
                        end
                    endcase
                end
            end
            S_INS: begin
                st_we.val_we = 1'b1;
                st_we.lnk_we = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                cur_next     = al_slot;
                state_next   = S_FIN;
                if (empty) begin
                    head_next = al_slot;
                    tail_next = al_slot;
                end else if (op_reg == OP_INS_FRONT) begin
                    lnk_wdata = head_reg;
                    head_next = al_slot;
                end else begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL: begin
                // hook the new slot behind the old tail
                st_we.lnk_we = 1'b1;
                lnk_waddr    = tail_reg;
                lnk_wdata    = cur_reg;
                tail_next    = cur_reg;
                state_next   = S_FIN;
            end
            S_POP: begin
                rem_next    = val_rdata;
                head_next   = lnk_rdata;
                al_ctl.give = 1'b1;
                al_give     = head_reg;
                cnt_next    = cnt_reg - CW'(1);
                state_next  = S_FIN;
            end
            S_WALK: begin
                if (hit) begin
                    rem_next    = val_rdata;
                    al_ctl.give = 1'b1;
                    cnt_next    = cnt_reg - CW'(1);
                    if (idx_reg == '0) begin
                        head_next = lnk_rdata;
                    end else begin
                        // unlink: predecessor skips the matched slot
                        st_we.lnk_we = 1'b1;
                        lnk_waddr    = prev_reg;
                        lnk_wdata    = lnk_rdata;
                    end
                    if (last) begin
                        tail_next = prev_reg;
                    end
                    state_next = S_FIN;
                end else if (last) begin
                    stat_next  = ST_MISS;
                    state_next = S_FIN;
                end else begin
                    prev_next = cur_reg;
                    cur_next  = lnk_rdata;
                    idx_next  = idx_reg + CW'(1);
                end
            end
            S_FIN: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.status        = stat_reg;
                    m_data_next.removed_value = rem_reg;
                    m_data_next.element_count = ECNT_W'(cnt_reg);
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        stat_reg   <= stat_next;
        rem_reg    <= rem_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(CAPACITY))
        else $error("element count past capacity");
    a_walk_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> idx_reg < cnt_reg)
        else $error("walk ran past the end of the list");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != S_IDLE)
        else $error("sequencer idle right after taking an item");
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the final step");
    a_count_moves_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_INS |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("insert did not add exactly one element");

endmodule
